// ===== design/pifba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pifba_pkg;

  localparam int unsigned IFACES_DEF = 4;
  localparam int unsigned FLOWS_DEF = 64;
  localparam logic [31:0] FLUSH_DEFAULT = 32'(50 * 1024 * 1024);

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SAVED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  iface;
    logic        iface_ok;
    logic        is_v6;
    logic [63:0] lh;
    logic [63:0] ll;
    logic [63:0] rh;
    logic [63:0] rl;
    logic [15:0] pkt_len;
    logic [5:0]  entry_index;
  } work_t;

  typedef struct packed {
    logic [5:0]  hit_index;
    logic        new_flow;
    logic        table_full;
    logic        flush_request;
    logic [63:0] byte_count;
    logic [63:0] local_hi;
    logic [63:0] local_lo;
    logic [63:0] remote_hi;
    logic [63:0] remote_lo;
    logic        entry_valid;
    logic [31:0] unsaved_bytes;
  } result_t;

endpackage
`default_nettype wire

// ===== design/per_interface_flow_byte_accounting.sv =====
// Per-interface flow byte accounting.
// Input channel (in_valid/in_ready): one word per command. A count command orders
// the packet's addresses into local and remote, looks the pair up in the
// interface's IPv4 or IPv6 table, inserts it on a miss when the table has room and
// adds the length to the entry counter and to the interface's unsaved total. Read, clear and
// mark-saved commands act on one entry or one interface.
// Result channel (out_valid/out_ready): exactly one word per input word, in order.
// The back end walks the table one entry per cycle through the registered read
// port of the flow memory, and takes the next command only once the result of
// the last one has been loaded into the result register.
// A two-word queue sits between the front end and the back end, and the result
// register parts the back end from the receiver, so a stalled receiver holds
// one finished word while the next one is worked on.
// Reset (synchronous, rst_n low) empties all tables and unsaved totals and
// sets flush_threshold to 52428800; table contents need no clearing pass.
// flush_threshold lives at APB address 0; the user must write it only while idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none
module per_interface_flow_byte_accounting import pifba_pkg::*; #(
  parameter int unsigned IFACES = IFACES_DEF,
  parameter int unsigned FLOWS  = FLOWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [1:0]  in_iface,
  input  wire logic        in_is_v6,
  input  wire logic [63:0] in_src_hi,
  input  wire logic [63:0] in_src_lo,
  input  wire logic [63:0] in_dst_hi,
  input  wire logic [63:0] in_dst_lo,
  input  wire logic [15:0] in_pkt_len,
  input  wire logic        in_outbound,
  input  wire logic [5:0]  in_entry_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_hit_index,
  output logic             out_new_flow,
  output logic             out_table_full,
  output logic             out_flush_request,
  output logic [63:0]      out_byte_count,
  output logic [63:0]      out_local_hi,
  output logic [63:0]      out_local_lo,
  output logic [63:0]      out_remote_hi,
  output logic [63:0]      out_remote_lo,
  output logic             out_entry_valid,
  output logic [31:0]      out_unsaved_bytes,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] thr_r;
  logic        q_valid, q_pop;
  work_t       q_data;
  result_t     res;

  // The only register is flush_threshold at word address zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= FLUSH_DEFAULT;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      thr_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? thr_r : 32'd0;

  pifba_front #(.IFACES(IFACES)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_iface, .in_is_v6,
    .in_src_hi, .in_src_lo, .in_dst_hi, .in_dst_lo, .in_pkt_len, .in_outbound,
    .in_entry_index, .q_valid, .q_data, .q_pop
  );

  pifba_back #(.IFACES(IFACES), .FLOWS(FLOWS)) u_back (
    .clk, .rst_n, .threshold(thr_r), .q_valid, .q_data, .q_pop,
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_hit_index     = res.hit_index;
  assign out_new_flow      = res.new_flow;
  assign out_table_full    = res.table_full;
  assign out_flush_request = res.flush_request;
  assign out_byte_count    = res.byte_count;
  assign out_local_hi      = res.local_hi;
  assign out_local_lo      = res.local_lo;
  assign out_remote_hi     = res.remote_hi;
  assign out_remote_lo     = res.remote_lo;
  assign out_entry_valid   = res.entry_valid;
  assign out_unsaved_bytes = res.unsaved_bytes;

`ifndef SYNTHESIS
  a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_new_flow && !out_entry_valid)
    else $error("dropped packet reported as counted");
  a_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flush_request |-> out_unsaved_bytes == 32'd0)
    else $error("flush without zeroed total");
  a_new_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_flow |-> out_entry_valid)
    else $error("new flow without entry");
`endif

endmodule
`default_nettype wire

// ===== design/pifba_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pifba_front import pifba_pkg::*; #(
  parameter int unsigned IFACES = IFACES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [1:0]  in_iface,
  input  wire logic        in_is_v6,
  input  wire logic [63:0] in_src_hi,
  input  wire logic [63:0] in_src_lo,
  input  wire logic [63:0] in_dst_hi,
  input  wire logic [63:0] in_dst_lo,
  input  wire logic [15:0] in_pkt_len,
  input  wire logic        in_outbound,
  input  wire logic [5:0]  in_entry_index,
  output logic             q_valid,
  output work_t            q_data,
  input  wire logic        q_pop
);

  work_t       cls;
  work_t       fifo_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;

  // Order the addresses into local and remote; IPv4 keeps only the low 32 bits.
  always_comb begin
    cls.cmd         = cmd_t'(in_command);
    cls.iface       = in_iface;
    cls.iface_ok    = (int'(in_iface) < IFACES);
    cls.is_v6       = in_is_v6;
    cls.pkt_len     = in_pkt_len;
    cls.entry_index = in_entry_index;
    if (in_outbound) begin
      cls.lh = in_src_hi; cls.ll = in_src_lo; cls.rh = in_dst_hi; cls.rl = in_dst_lo;
    end else begin
      cls.lh = in_dst_hi; cls.ll = in_dst_lo; cls.rh = in_src_hi; cls.rl = in_src_lo;
    end
    if (!in_is_v6) begin
      cls.lh = '0;
      cls.rh = '0;
      cls.ll = {32'd0, cls.ll[31:0]};
      cls.rl = {32'd0, cls.rl[31:0]};
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = fifo_r[rptr_r];

  assign wptr_nxt = push ? ~wptr_r : wptr_r;
  assign rptr_nxt = q_pop ? ~rptr_r : rptr_r;
  assign cnt_nxt  = cnt_r + 2'(push) - 2'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== design/pifba_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pifba_back import pifba_pkg::*; #(
  parameter int unsigned IFACES = IFACES_DEF,
  parameter int unsigned FLOWS  = FLOWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] threshold,
  input  wire logic        q_valid,
  input  work_t            q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output result_t          out_res
);

  localparam int unsigned DEPTH = IFACES * FLOWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = (IFACES > 1) ? $clog2(IFACES) : 1;
  localparam int unsigned EW    = $clog2(FLOWS + 1);

  logic [63:0]  v4_key_mem [DEPTH];
  logic [63:0]  v4_cnt_mem [DEPTH];
  logic [255:0] v6_key_mem [DEPTH];
  logic [63:0]  v6_cnt_mem [DEPTH];

  logic [63:0]  rd4_key_r, rd4_cnt_r, rd6_cnt_r;
  logic [255:0] rd6_key_r;

  state_t       state_r, state_nxt;
  work_t        wk_r, cur;
  result_t      res_r, res_nxt, out_res_r;
  logic         out_valid_r;
  logic [EW-1:0] scan_r, scan_nxt;
  logic [EW-1:0] v4_used_r [IFACES];
  logic [EW-1:0] v6_used_r [IFACES];
  logic [EW-1:0] v4_used_nxt [IFACES];
  logic [EW-1:0] v6_used_nxt [IFACES];
  logic [31:0]  pend_r [IFACES];
  logic [31:0]  pend_nxt [IFACES];

  logic [IW-1:0] ifi;
  logic [EW-1:0] used_cur;
  logic [31:0]   pend_cur, pend_sat, pend_new;
  logic [32:0]   pend_sum;
  logic          flush;
  logic [63:0]   rd_cnt, cnt_sat;
  logic [64:0]   cnt_sum;
  logic [AW-1:0] base, raddr, waddr;
  logic          match, scan_last, full, rd_ok, out_free;
  logic          miss_c, hit_c, load_out;
  logic          we4, we6, wc4, wc6;
  logic [63:0]   wcnt;

  assign cur      = (state_r == ST_IDLE) ? q_data : wk_r;
  assign ifi      = IW'(cur.iface);
  assign used_cur = cur.is_v6 ? v6_used_r[ifi] : v4_used_r[ifi];
  assign pend_cur = pend_r[ifi];
  assign base     = AW'(int'(ifi) * FLOWS);

  assign pend_sum = {1'b0, pend_cur} + 33'(cur.pkt_len);
  assign pend_sat = pend_sum[32] ? '1 : pend_sum[31:0];
  assign flush    = (pend_sat >= threshold);
  assign pend_new = flush ? 32'd0 : pend_sat;

  assign rd_cnt  = cur.is_v6 ? rd6_cnt_r : rd4_cnt_r;
  assign cnt_sum = {1'b0, rd_cnt} + 65'(cur.pkt_len);
  assign cnt_sat = cnt_sum[64] ? '1 : cnt_sum[63:0];

  assign match = cur.is_v6 ? (rd6_key_r == {cur.lh, cur.ll, cur.rh, cur.rl})
                           : (rd4_key_r == {cur.ll[31:0], cur.rl[31:0]});
  assign scan_last = (int'(scan_r) + 1 >= int'(used_cur));
  assign full      = (int'(used_cur) >= FLOWS);
  assign rd_ok     = (int'(cur.entry_index) < int'(used_cur));
  assign out_free  = !out_valid_r || out_ready;

  assign miss_c = (state_r == ST_IDLE && q_valid && cur.iface_ok && cur.cmd == CMD_COUNT &&
                   used_cur == '0) || (state_r == ST_SCAN && !match && scan_last);
  assign hit_c  = (state_r == ST_SCAN) && match;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (cur.iface_ok && cur.cmd == CMD_READ && rd_ok) begin
            state_nxt = ST_RDWAIT;
          end else if (cur.iface_ok && cur.cmd == CMD_COUNT && used_cur != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (match || scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RDWAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    load_out    = 1'b0;
    raddr       = '0;
    scan_nxt    = scan_r;
    res_nxt     = res_r;
    v4_used_nxt = v4_used_r;
    v6_used_nxt = v6_used_r;
    pend_nxt    = pend_r;
    we4 = 1'b0; we6 = 1'b0; wc4 = 1'b0; wc6 = 1'b0;
    waddr = '0;
    wcnt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          res_nxt  = '0;
          scan_nxt = '0;
          raddr    = base;
          if (cur.iface_ok) begin
            case (cur.cmd)
              CMD_CLEAR: begin
                v4_used_nxt[ifi] = '0;
                v6_used_nxt[ifi] = '0;
                pend_nxt[ifi]    = '0;
              end
              CMD_SAVED: pend_nxt[ifi] = '0;
              CMD_READ: begin
                res_nxt.unsaved_bytes = pend_cur;
                raddr = base + AW'(cur.entry_index);
              end
              default: begin
                res_nxt.local_hi  = cur.lh;
                res_nxt.local_lo  = cur.ll;
                res_nxt.remote_hi = cur.rh;
                res_nxt.remote_lo = cur.rl;
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        raddr    = base + AW'(scan_nxt);
      end
      ST_RDWAIT: begin
        res_nxt.hit_index   = 6'(cur.entry_index);
        res_nxt.entry_valid = 1'b1;
        res_nxt.byte_count  = rd_cnt;
        if (cur.is_v6) begin
          {res_nxt.local_hi, res_nxt.local_lo, res_nxt.remote_hi, res_nxt.remote_lo} =
            rd6_key_r;
        end else begin
          res_nxt.local_lo  = {32'd0, rd4_key_r[63:32]};
          res_nxt.remote_lo = {32'd0, rd4_key_r[31:0]};
        end
      end
      ST_DONE: load_out = out_free;
      default: ;
    endcase

    if (miss_c) begin
      if (full) begin
        res_nxt.table_full    = 1'b1;
        res_nxt.unsaved_bytes = pend_cur;
      end else begin
        waddr = base + AW'(used_cur);
        wcnt  = 64'(cur.pkt_len);
        we4   = !cur.is_v6; wc4 = !cur.is_v6;
        we6   = cur.is_v6;  wc6 = cur.is_v6;
        if (cur.is_v6) begin
          v6_used_nxt[ifi] = used_cur + 1'b1;
        end else begin
          v4_used_nxt[ifi] = used_cur + 1'b1;
        end
        res_nxt.new_flow      = 1'b1;
        res_nxt.hit_index     = 6'(used_cur);
        res_nxt.byte_count    = wcnt;
        res_nxt.entry_valid   = 1'b1;
        res_nxt.flush_request = flush;
        res_nxt.unsaved_bytes = pend_new;
        pend_nxt[ifi]         = pend_new;
      end
    end else if (hit_c) begin
      waddr = base + AW'(scan_r);
      wcnt  = cnt_sat;
      wc4   = !cur.is_v6;
      wc6   = cur.is_v6;
      res_nxt.hit_index     = 6'(scan_r);
      res_nxt.byte_count    = cnt_sat;
      res_nxt.entry_valid   = 1'b1;
      res_nxt.flush_request = flush;
      res_nxt.unsaved_bytes = pend_new;
      pend_nxt[ifi]         = pend_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < IFACES; k++) begin
        v4_used_r[k] <= '0;
        v6_used_r[k] <= '0;
        pend_r[k]    <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      v4_used_r <= v4_used_nxt;
      v6_used_r <= v6_used_nxt;
      pend_r    <= pend_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    res_r  <= res_nxt;
    if (q_pop) begin
      wk_r <= q_data;
    end
    if (load_out) begin
      out_res_r <= res_r;
    end
  end

  // Flow tables: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (we4) begin
      v4_key_mem[waddr] <= {cur.ll[31:0], cur.rl[31:0]};
    end
    if (we6) begin
      v6_key_mem[waddr] <= {cur.lh, cur.ll, cur.rh, cur.rl};
    end
    if (wc4) begin
      v4_cnt_mem[waddr] <= wcnt;
    end
    if (wc6) begin
      v6_cnt_mem[waddr] <= wcnt;
    end
    rd4_key_r <= v4_key_mem[raddr];
    rd4_cnt_r <= v4_cnt_mem[raddr];
    rd6_key_r <= v6_key_mem[raddr];
    rd6_cnt_r <= v6_cnt_mem[raddr];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire
